// ===== sv/ncc_pkg.sv =====
// Shared types and constants for the NCC window matching cost block.
`timescale 1ns / 1ps
`default_nettype none
package ncc_pkg;

   localparam logic [7:0] COST_FLAT = 8'd255;
   localparam logic [7:0] COST_MID  = 8'd128;
   localparam logic [7:0] T_NEG_MAX = 8'd127;
   localparam int         A_SHIFT   = 14;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_DIFF,
      B_PROD,
      B_SRCH,
      B_DONE
   } back_state_type;

endpackage
`default_nettype wire

// ===== sv/ncc_if.sv =====
// Valid/ready channel interfaces for pixel pairs and cost results.
`timescale 1ns / 1ps
`default_nettype none
interface ncc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ref_pixel;
   logic [7:0] match_pixel;
   logic       window_end;
   modport source (output valid, ref_pixel, match_pixel, window_end, input ready);
   modport sink   (input valid, ref_pixel, match_pixel, window_end, output ready);
endinterface

interface ncc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cost;
   logic       flat_window;
   modport source (output valid, cost, flat_window, input ready);
   modport sink   (input valid, cost, flat_window, output ready);
endinterface
`default_nettype wire

// ===== sv/ncc_window_matching_cost.sv =====
// Top level: NCC stereo matching cost over one correlation window.
// A pair word is taken whenever it is valid and the sums queue is not full.
// A window end reaches the result register via the sums queue and states MUL, DIFF, PROD;
// windows neither flat nor zero-covariance then also run the SRCH cost search.
// Two finished windows can queue while the back end works; one result at a time.
// Synchronous active-high reset clears the sums, the queue and the result valid.
`timescale 1ns / 1ps
`default_nettype none
module ncc_window_matching_cost #(
   parameter int RADIUS_Y = 1,
   parameter int RADIUS_X = 1
) (
   input  wire logic clock,
   input  wire logic reset,
   ncc_req_if.sink   req_bus,
   ncc_rsp_if.source rsp_bus
);
   localparam int NPAIR = (2 * RADIUS_Y + 1) * (2 * RADIUS_X + 1);
   localparam int CW    = $clog2(NPAIR + 1);
   localparam int SW    = 8 + CW;
   localparam int QW    = 16 + CW;
   localparam int EW    = CW + 2 * SW + 3 * QW;

   logic          q_push, q_full, q_pop, q_valid;
   logic [CW-1:0] n_f, n_b;
   logic [SW-1:0] sr_f, sm_f, sr_b, sm_b;
   logic [QW-1:0] srr_f, smm_f, sx_f, srr_b, smm_b, sx_b;
   logic [EW-1:0] q_wdata, q_rdata;

   ncc_front #(.NPAIR(NPAIR), .CW(CW), .SW(SW), .QW(QW)) u_front (
      .clock(clock), .reset(reset), .req_bus(req_bus), .q_full(q_full), .q_push(q_push),
      .n_out(n_f), .sr_out(sr_f), .sm_out(sm_f),
      .srr_out(srr_f), .smm_out(smm_f), .sx_out(sx_f)
   );

   assign q_wdata = {n_f, sr_f, sm_f, srr_f, smm_f, sx_f};

   ncc_fifo #(.WIDTH(EW)) u_fifo (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_wdata), .full(q_full),
      .pop(q_pop), .pop_data(q_rdata), .not_empty(q_valid)
   );

   assign {n_b, sr_b, sm_b, srr_b, smm_b, sx_b} = q_rdata;

   ncc_back #(.CW(CW), .SW(SW), .QW(QW)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .n_in(n_b), .sr_in(sr_b), .sm_in(sm_b), .srr_in(srr_b), .smm_in(smm_b),
      .sx_in(sx_b), .rsp_bus(rsp_bus)
   );
endmodule
`default_nettype wire

// ===== sv/ncc_fifo.sv =====
// Two-entry queue of window sums between front and back.
`timescale 1ns / 1ps
`default_nettype none
module ncc_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  not_empty
);
   logic [WIDTH-1:0] mem_ff [2];
   logic [WIDTH-1:0] mem_in [2];
   logic             wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   always_comb begin
      mem_in = mem_ff;
      if (push) begin
         mem_in[wptr_ff] = push_data;
      end
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = pop ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign pop_data  = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/ncc_front.sv =====
// Front end: accumulates pair count and sums, hands a window off on its last word.
`timescale 1ns / 1ps
`default_nettype none
module ncc_front #(
   parameter int NPAIR = 9,
   parameter int CW    = 4,
   parameter int SW    = 12,
   parameter int QW    = 20
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ncc_req_if.sink    req_bus,
   input  wire logic  q_full,
   output logic       q_push,
   output logic [CW-1:0] n_out,
   output logic [SW-1:0] sr_out,
   output logic [SW-1:0] sm_out,
   output logic [QW-1:0] srr_out,
   output logic [QW-1:0] smm_out,
   output logic [QW-1:0] sx_out
);
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] sr_ff, sr_in, sm_ff, sm_in;
   logic [QW-1:0] srr_ff, srr_in, smm_ff, smm_in, sx_ff, sx_in;
   logic          take, add;
   logic [CW-1:0] cnt_nx;
   logic [SW-1:0] sr_nx, sm_nx;
   logic [QW-1:0] srr_nx, smm_nx, sx_nx;
   logic [15:0]   rr, mm, rm;

   assign req_bus.ready = !q_full;
   assign take = req_bus.valid && !q_full;
   assign add  = cnt_ff < CW'(NPAIR);
   assign rr   = req_bus.ref_pixel * req_bus.ref_pixel;
   assign mm   = req_bus.match_pixel * req_bus.match_pixel;
   assign rm   = req_bus.ref_pixel * req_bus.match_pixel;

   always_comb begin
      cnt_nx = cnt_ff;
      sr_nx  = sr_ff;
      sm_nx  = sm_ff;
      srr_nx = srr_ff;
      smm_nx = smm_ff;
      sx_nx  = sx_ff;
      if (add) begin
         cnt_nx = cnt_ff + CW'(1);
         sr_nx  = sr_ff + SW'(req_bus.ref_pixel);
         sm_nx  = sm_ff + SW'(req_bus.match_pixel);
         srr_nx = srr_ff + QW'(rr);
         smm_nx = smm_ff + QW'(mm);
         sx_nx  = sx_ff + QW'(rm);
      end
      q_push = take && req_bus.window_end;
      cnt_in = cnt_ff;
      sr_in  = sr_ff;
      sm_in  = sm_ff;
      srr_in = srr_ff;
      smm_in = smm_ff;
      sx_in  = sx_ff;
      if (take) begin
         if (req_bus.window_end) begin
            cnt_in = '0;
            sr_in  = '0;
            sm_in  = '0;
            srr_in = '0;
            smm_in = '0;
            sx_in  = '0;
         end else begin
            cnt_in = cnt_nx;
            sr_in  = sr_nx;
            sm_in  = sm_nx;
            srr_in = srr_nx;
            smm_in = smm_nx;
            sx_in  = sx_nx;
         end
      end
   end

   assign n_out   = cnt_nx;
   assign sr_out  = sr_nx;
   assign sm_out  = sm_nx;
   assign srr_out = srr_nx;
   assign smm_out = smm_nx;
   assign sx_out  = sx_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sr_ff  <= '0;
         sm_ff  <= '0;
         srr_ff <= '0;
         smm_ff <= '0;
         sx_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sr_ff  <= sr_in;
         sm_ff  <= sm_in;
         srr_ff <= srr_in;
         smm_ff <= smm_in;
         sx_ff  <= sx_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/ncc_back.sv =====
// Back end: variances, covariance, exact cost search and result register.
`timescale 1ns / 1ps
`default_nettype none
module ncc_back #(
   parameter int CW = 4,
   parameter int SW = 12,
   parameter int QW = 20
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   output logic          q_pop,
   input  wire logic [CW-1:0] n_in,
   input  wire logic [SW-1:0] sr_in,
   input  wire logic [SW-1:0] sm_in,
   input  wire logic [QW-1:0] srr_in,
   input  wire logic [QW-1:0] smm_in,
   input  wire logic [QW-1:0] sx_in,
   ncc_rsp_if.source     rsp_bus
);
   localparam int VW = CW + QW;
   localparam int PW = 2 * VW;
   localparam int AW = PW + 16;

   ncc_pkg::back_state_type st_ff, st_in;

   logic [CW-1:0] n_ff;
   logic [SW-1:0] sr_ff, sm_ff;
   logic [QW-1:0] srr_ff, smm_ff, sx_ff;
   logic [VW-1:0] nrr_ff, rr_ff, nmm_ff, mm_ff, nx_ff, rm_ff;
   logic [VW-1:0] vr_ff, vm_ff, mag_ff;
   logic          neg_ff, zero_ff;
   logic [AW-1:0] p_ff, a2_ff, acc_ff, inc_ff;
   logic [7:0]    t_ff;
   logic [7:0]    cost_ff, cost_in;
   logic          flat_ff, flat_in;
   logic [AW-1:0] acc_nx, pp, a2_w;
   logic          flat_w, hit_pos, stop_neg, srch_done, load_out;

   assign pp      = AW'(vr_ff * vm_ff);
   assign a2_w    = AW'(mag_ff * mag_ff) << ncc_pkg::A_SHIFT;
   assign flat_w  = (vr_ff == '0) || (vm_ff == '0);
   assign acc_nx  = acc_ff + inc_ff;
   assign hit_pos = acc_ff >= a2_ff;
   assign stop_neg = (t_ff == ncc_pkg::T_NEG_MAX) || (acc_nx > a2_ff);
   assign srch_done = neg_ff ? stop_neg : hit_pos;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ncc_pkg::B_IDLE: if (q_valid) st_in = ncc_pkg::B_MUL;
         ncc_pkg::B_MUL:  st_in = ncc_pkg::B_DIFF;
         ncc_pkg::B_DIFF: st_in = ncc_pkg::B_PROD;
         ncc_pkg::B_PROD: st_in = (flat_w || zero_ff) ? ncc_pkg::B_DONE : ncc_pkg::B_SRCH;
         ncc_pkg::B_SRCH: if (srch_done) st_in = ncc_pkg::B_DONE;
         ncc_pkg::B_DONE: if (rsp_bus.ready) st_in = ncc_pkg::B_IDLE;
         default:         st_in = ncc_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      load_out = 1'b0;
      cost_in  = cost_ff;
      flat_in  = flat_ff;
      case (st_ff)
         ncc_pkg::B_IDLE: q_pop = q_valid;
         ncc_pkg::B_PROD: begin
            load_out = flat_w || zero_ff;
            cost_in  = flat_w ? ncc_pkg::COST_FLAT : ncc_pkg::COST_MID;
            flat_in  = flat_w;
         end
         ncc_pkg::B_SRCH: begin
            load_out = srch_done;
            cost_in  = neg_ff ? ncc_pkg::COST_MID + t_ff : ncc_pkg::COST_MID - t_ff;
            flat_in  = 1'b0;
         end
         default: load_out = 1'b0;
      endcase
   end

   assign rsp_bus.valid       = st_ff == ncc_pkg::B_DONE;
   assign rsp_bus.cost        = cost_ff;
   assign rsp_bus.flat_window = flat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ncc_pkg::B_IDLE;
      end else begin
         st_ff <= st_in;
      end
      if (q_pop) begin
         n_ff   <= n_in;
         sr_ff  <= sr_in;
         sm_ff  <= sm_in;
         srr_ff <= srr_in;
         smm_ff <= smm_in;
         sx_ff  <= sx_in;
      end
      if (st_ff == ncc_pkg::B_MUL) begin
         nrr_ff <= VW'(n_ff * srr_ff);
         nmm_ff <= VW'(n_ff * smm_ff);
         nx_ff  <= VW'(n_ff * sx_ff);
         rr_ff  <= VW'(sr_ff * sr_ff);
         mm_ff  <= VW'(sm_ff * sm_ff);
         rm_ff  <= VW'(sr_ff * sm_ff);
      end
      if (st_ff == ncc_pkg::B_DIFF) begin
         vr_ff   <= nrr_ff - rr_ff;
         vm_ff   <= nmm_ff - mm_ff;
         neg_ff  <= nx_ff < rm_ff;
         zero_ff <= nx_ff == rm_ff;
         mag_ff  <= (nx_ff < rm_ff) ? rm_ff - nx_ff : nx_ff - rm_ff;
      end
      if (st_ff == ncc_pkg::B_PROD) begin
         p_ff   <= pp;
         a2_ff  <= a2_w;
         acc_ff <= '0;
         inc_ff <= pp;
         t_ff   <= '0;
      end
      if (st_ff == ncc_pkg::B_SRCH && !srch_done) begin
         acc_ff <= acc_nx;
         inc_ff <= inc_ff + (p_ff << 1);
         t_ff   <= t_ff + 8'd1;
      end
      if (load_out) begin
         cost_ff <= cost_in;
         flat_ff <= flat_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/ncc_checker.sv =====
// Port-level checker for the NCC matching cost block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ncc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_window_end,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_cost,
   input wire logic       rsp_flat_window
);
   logic [7:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff + {7'd0, req_valid && req_ready && req_window_end}
                - {7'd0, rsp_valid && rsp_ready};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_flat_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flat_window |-> rsp_cost == 8'd255)
      else $error("flat window without full cost");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 8'd0)
      else $error("result without a finished window");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cost))
      else $error("stalled result changed");
endmodule

bind ncc_window_matching_cost ncc_checker u_ncc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_bus.valid),
   .req_ready(req_bus.ready),
   .req_window_end(req_bus.window_end),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_cost(rsp_bus.cost),
   .rsp_flat_window(rsp_bus.flat_window)
);
`default_nettype wire

// ===== test/ncc_tb_if.sv =====
// Result word type shared by the testbench.
`timescale 1ns / 1ps
package ncc_tb_types;
   typedef struct packed {
      logic [7:0] cost;
      logic       flat_window;
   } cost_word_type;
endpackage

// ===== test/testbench.sv =====
// Testbench for the NCC window matching cost: random pixel windows, scoreboard checks cost.
`timescale 1ns / 1ps
module testbench;
   localparam int MAX_PAIRS = 9;
   localparam int WATCHDOG_LIMIT = 20000;

   class cost_scoreboard;
      longint unsigned pairs, s_r, s_m, s_rr, s_mm, s_rm;
      ncc_tb_types::cost_word_type pending_costs[$];
      int mismatches;

      function void clear_sums();
         pairs = 0; s_r = 0; s_m = 0; s_rr = 0; s_mm = 0; s_rm = 0;
      endfunction

      function bit fits(longint signed cov, int t, longint unsigned prod);
         bit [127:0] lhs, rhs;
         longint unsigned a;
         a = (cov < 0 ? -cov : cov) * 128;
         lhs = 128'(a) * 128'(a);
         rhs = 128'(t * t) * 128'(prod);
         if (t >= 0) return (cov <= 0) || (lhs <= rhs);
         return (cov < 0) && (lhs >= rhs);
      endfunction

      function void note_pair(logic [7:0] r, logic [7:0] m, logic last);
         longint unsigned vr, vm;
         longint signed cov;
         ncc_tb_types::cost_word_type w;
         if (pairs < MAX_PAIRS) begin
            pairs++; s_r += r; s_m += m;
            s_rr += r * r; s_mm += m * m; s_rm += r * m;
         end
         if (!last) return;
         vr = pairs * s_rr - s_r * s_r;
         vm = pairs * s_mm - s_m * s_m;
         if (vr == 0 || vm == 0) begin
            w.cost = 8'd255;
            w.flat_window = 1'b1;
         end else begin
            cov = longint'(pairs * s_rm) - longint'(s_r * s_m);
            w.cost = 8'd0;
            w.flat_window = 1'b0;
            for (int k = 255; k >= 0; k--) begin
               if (fits(cov, 128 - k, vr * vm)) begin
                  w.cost = k[7:0];
                  break;
               end
            end
         end
         pending_costs.push_back(w);
         clear_sums();
      endfunction

      function void check_cost(logic [7:0] cost, logic flat);
         ncc_tb_types::cost_word_type w;
         if (pending_costs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word cost=%0d flat=%0b", cost, flat);
            return;
         end
         w = pending_costs.pop_front();
         if (w.cost !== cost || w.flat_window !== flat) begin
            mismatches++;
            if (mismatches <= 10)
               $display("cost mismatch: expected %0d/%0b actual %0d/%0b",
                        w.cost, w.flat_window, cost, flat);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   ncc_req_if req_bus();
   ncc_rsp_if rsp_bus();
   cost_scoreboard board = new();
   int idle_cycles;
   bit stim_done;

   ncc_window_matching_cost dut (.clock(clock), .reset(reset),
                                 .req_bus(req_bus), .rsp_bus(rsp_bus));

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.ref_pixel = '0;
      req_bus.match_pixel = '0;
      req_bus.window_end = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            board.note_pair(req_bus.ref_pixel, req_bus.match_pixel, req_bus.window_end);
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_cost(rsp_bus.cost, rsp_bus.flat_window);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: random stalls per word, with quiet stretches
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (gap == 0) rsp_bus.ready <= 1'b1;
         else begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
         @(posedge clock iff rsp_bus.valid);
      end
   end

   task automatic send_pair(logic [7:0] r, logic [7:0] m, logic last, bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.ref_pixel <= r;
      req_bus.match_pixel <= m;
      req_bus.window_end <= last;
      @(posedge clock iff req_bus.ready);
   endtask

   task automatic send_window(int len, int mode, bit burst);
      logic [7:0] r, m;
      for (int i = 0; i < len; i++) begin
         r = 8'($urandom_range(0, 255));
         case (mode)
            1: m = r;
            2: m = 8'd255 - r;
            3: m = 8'd77;
            4: m = r ^ 8'($urandom_range(0, 15));
            default: m = 8'($urandom_range(0, 255));
         endcase
         send_pair(r, m, i == len - 1, burst);
      end
   endtask

   initial begin
      int len;
      bit burst;
      len = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, single pair, flat, identical, inverted, overlong
      send_pair(8'd0, 8'd255, 1'b1, 1'b0);
      send_pair(8'd0, 8'd0, 1'b0, 1'b0);
      send_pair(8'd255, 8'd255, 1'b1, 1'b0);
      send_pair(8'd0, 8'd255, 1'b0, 1'b0);
      send_pair(8'd255, 8'd0, 1'b1, 1'b0);
      send_window(9, 1, 1'b1);
      send_window(9, 3, 1'b0);
      send_window(12, 0, 1'b1);
      for (int i = 0; i < 40; i++) send_pair(8'd255, 8'd255, 1'b0, 1'b1);
      send_window(5, 2, 1'b1);
      // random windows; mostly 9 pairs, some short, a few overlong
      while (len < 1370) begin
         int n;
         n = $urandom_range(0, 9);
         n = (n < 6) ? 9 : (n < 9) ? $urandom_range(1, 8) : $urandom_range(10, 14);
         burst = ($urandom_range(0, 4) == 0);
         send_window(n, $urandom_range(0, 5), burst);
         len += n;
      end
      req_bus.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      @(posedge clock iff stim_done);
      while (board.pending_costs.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
